[design/mrlc_pkg.sv]
// Shared types, character codes and prefix constants for the modem reply line classifier.
// Used by mrlc_front, mrlc_back and modem_reply_line_classifier; depends on nothing.
`default_nettype none

package mrlc_pkg;

  // Line buffer size and the limits derived from it.
  localparam int BUFFER_BYTES = 240;
  localparam int IDX_W = 8;
  // A frame keeps counting past the buffer, up to a length of 255 plus overhead.
  localparam int FILL_W = 9;
  localparam int HEAD_DEPTH = 12;
  localparam int PFX_W = 8 * HEAD_DEPTH;

  localparam logic [FILL_W-1:0] NORMAL_LIMIT = FILL_W'(BUFFER_BYTES - 2);
  localparam logic [FILL_W-1:0] STORE_LIMIT = FILL_W'(BUFFER_BYTES - 1);
  localparam logic [FILL_W-1:0] FRAME_OVERHEAD = FILL_W'(18);
  localparam logic [FILL_W-1:0] LEN_HI_POS = FILL_W'(13);
  localparam logic [FILL_W-1:0] LEN_DONE_FILL = FILL_W'(15);

  // Control characters.
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] HEX_ALPHA_BIAS = 8'h37;
  localparam logic [7:0] HEX_DIGIT_BIAS = 8'h30;

  // Line prefixes; all but PFX_SMS are left aligned in a field of HEAD_DEPTH bytes.
  localparam logic [31:0] PFX_SMS = "0891";
  localparam logic [PFX_W-1:0] PFX_TIME = {"*PSUTTZ:", 32'h0};
  localparam logic [PFX_W-1:0] PFX_SIG = {"+CSQ: ", 48'h0};
  localparam logic [PFX_W-1:0] PFX_CLOSED = {"CLOSED", 48'h0};
  localparam logic [PFX_W-1:0] PFX_FAIL = "CONNECT FAIL";
  localparam int LEN_TIME = 8;
  localparam int LEN_SIG = 6;
  localparam int LEN_CLOSED = 6;
  localparam int LEN_FAIL = 12;

  // Item kinds.
  localparam logic MODE_RX = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Completed message kinds.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_AT     = 3'd1,
    EV_SMS    = 3'd2,
    EV_FRAME  = 3'd3,
    EV_TIME   = 3'd4,
    EV_SIGNAL = 3'd5
  } event_t;

  // Line assembly modes.
  typedef enum logic [3:0] {
    LM_NORMAL = 4'b0001,
    LM_FRAME  = 4'b0010,
    LM_TIME   = 4'b0100,
    LM_SIGNAL = 4'b1000
  } line_mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             write_valid;
    logic [IDX_W-1:0] write_index;
    logic [7:0]       write_byte;
    logic [2:0]       event_res;
    logic [7:0]       event_length;
    logic             link_lost;
  } result_t;

  // An item with its byte already decoded by the front end. The hex value is
  // the full byte-wide difference, since no digit check is made.
  typedef struct packed {
    item_t      item;
    logic       is_lf;
    logic       is_cr;
    logic       is_stx;
    logic       is_etx;
    logic [7:0] hex_val;
  } class_t;

  // True when the byte c at position p completes prefix pfx of length n,
  // given the bytes already stored at the head of the line.
  function automatic logic prefix_hit(input logic [HEAD_DEPTH-1:0][7:0] h,
                                      input logic [FILL_W-1:0] p,
                                      input logic [7:0] c,
                                      input logic [PFX_W-1:0] pfx,
                                      input int n);
    logic hit;
    hit = (p == FILL_W'(n - 1)) && (c == pfx[PFX_W-1-8*(n-1) -: 8]);
    for (int i = 0; i < HEAD_DEPTH - 1; i++) begin
      if (i < n - 1 && h[i] != pfx[PFX_W-1-8*i -: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[design/mrlc_front.sv]
// Front end: accepts input items, decodes the byte and holds them in a two-entry queue.
// Depends on mrlc_pkg.
`default_nettype none

module mrlc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire mrlc_pkg::item_t  item,
  output logic                  cls_valid,
  output mrlc_pkg::class_t      cls_item,
  input  wire logic             take
);

  mrlc_pkg::class_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_ok;
  logic             take_ok;
  mrlc_pkg::class_t decoded;

  // Decode the incoming byte.
  always_comb begin
    decoded.item = item;
    decoded.is_lf = (item.rx_byte == mrlc_pkg::CH_LF);
    decoded.is_cr = (item.rx_byte == mrlc_pkg::CH_CR);
    decoded.is_stx = (item.rx_byte == mrlc_pkg::CH_STX);
    decoded.is_etx = (item.rx_byte == mrlc_pkg::CH_ETX);
    if (item.rx_byte > mrlc_pkg::CH_NINE) begin
      decoded.hex_val = item.rx_byte - mrlc_pkg::HEX_ALPHA_BIAS;
    end else begin
      decoded.hex_val = item.rx_byte - mrlc_pkg::HEX_DIGIT_BIAS;
    end
  end

  assign full = (count == 2'd2);
  assign push_ok = push && !full;
  assign cls_valid = (count != 2'd0);
  assign take_ok = take && cls_valid;
  assign cls_item = q[rd_ptr];

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push_ok} - {1'b0, take_ok});
    end
  end

endmodule

`default_nettype wire

[design/mrlc_back.sv]
// Back end: runs the line assembly state machine on decoded items, one per cycle
// if its two-entry output queue for the results has room. Depends on mrlc_pkg.
`default_nettype none

module mrlc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cls_valid,
  input  wire mrlc_pkg::class_t  cls_item,
  output logic                   take,
  output logic                   empty,
  input  wire logic              pop,
  output mrlc_pkg::result_t      result
);

  localparam int HD = mrlc_pkg::HEAD_DEPTH;
  localparam int FW = mrlc_pkg::FILL_W;

  // Line state.
  mrlc_pkg::line_mode_t       line_mode, line_mode_next;
  logic [FW-1:0]              fill_index, fill_index_next;
  logic [7:0]                 frame_payload_len, frame_payload_len_next;
  logic [3:0]                 length_high_digit, length_high_digit_next;
  logic                       lost_flag, lost_flag_next;
  logic [HD-1:0][7:0]         line_head;

  // Per-item working signals.
  logic [FW-1:0]              pos;
  logic [FW-1:0]              pos_inc;
  logic [FW-1:0]              frame_end;
  logic [7:0]                 b;
  logic                       head_at_pos;
  logic                       head_at_zero;
  logic [HD-1:0]              head_we;
  mrlc_pkg::result_t          res;
  logic                       time_hit, sig_hit, lost_hit, sms_hit;

  // Output queue.
  mrlc_pkg::result_t          oq [2];
  logic                       wr_ptr, rd_ptr;
  logic [1:0]                 count;
  logic                       pop_ok;

  assign pop_ok = pop && (count != 2'd0);
  assign empty = (count == 2'd0);
  assign result = oq[rd_ptr];
  // An item is carried out when the output queue has room for its result.
  assign take = cls_valid && ((count != 2'd2) || pop_ok);

  assign pos = fill_index;
  assign pos_inc = fill_index + FW'(1);
  assign b = cls_item.item.rx_byte;

  // Prefix detection against the bytes of the current line.
  always_comb begin
    time_hit = mrlc_pkg::prefix_hit(line_head, pos, b, mrlc_pkg::PFX_TIME,
                                    mrlc_pkg::LEN_TIME);
    sig_hit = mrlc_pkg::prefix_hit(line_head, pos, b, mrlc_pkg::PFX_SIG,
                                   mrlc_pkg::LEN_SIG);
    lost_hit = mrlc_pkg::prefix_hit(line_head, pos, b, mrlc_pkg::PFX_CLOSED,
                                    mrlc_pkg::LEN_CLOSED)
            || mrlc_pkg::prefix_hit(line_head, pos, b, mrlc_pkg::PFX_FAIL,
                                    mrlc_pkg::LEN_FAIL);
    sms_hit = (pos >= FW'(4))
           && ({line_head[0], line_head[1], line_head[2], line_head[3]} == mrlc_pkg::PFX_SMS);
  end

  // Line assembly: next state and the result of one item.
  always_comb begin
    line_mode_next = line_mode;
    fill_index_next = fill_index;
    frame_payload_len_next = frame_payload_len;
    length_high_digit_next = length_high_digit;
    lost_flag_next = lost_flag;
    head_at_pos = 1'b0;
    head_at_zero = 1'b0;
    frame_end = FW'(frame_payload_len) + mrlc_pkg::FRAME_OVERHEAD;
    res = '0;

    if (cls_item.item.mode == mrlc_pkg::MODE_CLEAR) begin
      lost_flag_next = 1'b0;
    end else begin
      case (line_mode)
        mrlc_pkg::LM_FRAME: begin
          if (pos < mrlc_pkg::STORE_LIMIT) begin
            res.write_valid = 1'b1;
            res.write_index = pos[7:0];
            res.write_byte = b;
            head_at_pos = 1'b1;
          end
          // Only the low nibble of the high digit survives the shift by four.
          if (pos == mrlc_pkg::LEN_HI_POS) begin
            length_high_digit_next = cls_item.hex_val[3:0];
          end
          // The payload length is known once both hex digits are in; the low
          // digit's whole value is added, so a non-hex byte carries upward.
          if (pos_inc == mrlc_pkg::LEN_DONE_FILL) begin
            frame_payload_len_next = {length_high_digit, 4'h0} + cls_item.hex_val;
          end
          frame_end = FW'(frame_payload_len_next) + mrlc_pkg::FRAME_OVERHEAD;
          fill_index_next = pos_inc;
          if (pos_inc == frame_end && cls_item.is_etx) begin
            if (pos <= mrlc_pkg::NORMAL_LIMIT) begin
              res.event_res = mrlc_pkg::EV_FRAME;
              res.event_length = 8'(pos_inc + FW'(1));
            end
            line_mode_next = mrlc_pkg::LM_NORMAL;
            fill_index_next = '0;
            frame_payload_len_next = '0;
          end else if (pos_inc > frame_end) begin
            // Overrun: the frame is dropped without an event.
            line_mode_next = mrlc_pkg::LM_NORMAL;
            fill_index_next = '0;
            frame_payload_len_next = '0;
          end
        end
        mrlc_pkg::LM_TIME, mrlc_pkg::LM_SIGNAL: begin
          if (cls_item.is_lf) begin
            res.write_valid = 1'b1;
            res.write_index = pos[7:0];
            res.write_byte = 8'h00;
            head_at_pos = 1'b1;
            res.event_res = (line_mode == mrlc_pkg::LM_TIME) ? mrlc_pkg::EV_TIME
                                                             : mrlc_pkg::EV_SIGNAL;
            res.event_length = pos_inc[7:0];
            line_mode_next = mrlc_pkg::LM_NORMAL;
            fill_index_next = '0;
            frame_payload_len_next = '0;
          end else if (!cls_item.is_cr && pos < mrlc_pkg::STORE_LIMIT) begin
            res.write_valid = 1'b1;
            res.write_index = pos[7:0];
            res.write_byte = b;
            head_at_pos = 1'b1;
            fill_index_next = pos_inc;
          end
        end
        default: begin
          if (cls_item.is_lf || pos >= mrlc_pkg::NORMAL_LIMIT) begin
            // Line end: terminate it, and report it unless it is empty.
            res.write_valid = 1'b1;
            res.write_index = pos[7:0];
            res.write_byte = 8'h00;
            head_at_pos = 1'b1;
            if (pos != '0) begin
              res.event_res = sms_hit ? mrlc_pkg::EV_SMS : mrlc_pkg::EV_AT;
              res.event_length = pos_inc[7:0];
            end
            fill_index_next = '0;
          end else if (!cls_item.is_cr) begin
            res.write_valid = 1'b1;
            res.write_index = pos[7:0];
            res.write_byte = b;
            head_at_pos = 1'b1;
            fill_index_next = pos_inc;
            if (cls_item.is_stx) begin
              // Frame start: the start byte moves to the buffer head.
              res.write_index = '0;
              head_at_zero = 1'b1;
              fill_index_next = FW'(1);
              frame_payload_len_next = '0;
              line_mode_next = mrlc_pkg::LM_FRAME;
            end else if (time_hit) begin
              fill_index_next = '0;
              line_mode_next = mrlc_pkg::LM_TIME;
            end else if (sig_hit) begin
              fill_index_next = '0;
              line_mode_next = mrlc_pkg::LM_SIGNAL;
            end else if (lost_hit) begin
              fill_index_next = '0;
              lost_flag_next = 1'b1;
            end
          end
        end
      endcase
    end
    res.link_lost = lost_flag_next;

    // Head bytes kept for prefix matching.
    for (int i = 0; i < HD; i++) begin
      head_we[i] = take && ((head_at_pos && pos == FW'(i)) || (head_at_zero && i == 0));
    end
  end

  // Head byte storage; only bytes of the current line are ever compared.
  always_ff @(posedge clk) begin
    for (int i = 0; i < HD; i++) begin
      if (head_we[i]) begin
        line_head[i] <= res.write_byte;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= mrlc_pkg::LM_NORMAL;
      fill_index <= '0;
      frame_payload_len <= '0;
      length_high_digit <= '0;
      lost_flag <= 1'b0;
    end else if (take) begin
      line_mode <= line_mode_next;
      fill_index <= fill_index_next;
      frame_payload_len <= frame_payload_len_next;
      length_high_digit <= length_high_digit_next;
      lost_flag <= lost_flag_next;
    end
  end

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (take) begin
      oq[wr_ptr] <= res;
    end
  end

  // Output queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, take} - {1'b0, pop_ok});
    end
  end

endmodule

`default_nettype wire

[design/modem_reply_line_classifier.sv]
// Top level of the modem reply line classifier: front end, back end and checks.
// Depends on mrlc_pkg, mrlc_front and mrlc_back.
//
// Each transfer in carries one received modem byte (or a request to clear the
// link-lost flag) and produces exactly one result: the line-buffer write it
// causes, any message it completes and the current link-lost flag. The block
// sustains one item per clock cycle while neither side stalls; the back end's
// line state machine, which updates the fill index, mode and head bytes, sets
// that rate. A result reaches the output once its item has passed a two-entry
// input queue and then a two-entry result queue; each queue lets its side
// stall on its own.
`default_nettype none

module modem_reply_line_classifier (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire mrlc_pkg::item_t    item,
  output logic                    empty,
  input  wire logic               pop,
  output mrlc_pkg::result_t       result
);

  logic              cls_valid;
  mrlc_pkg::class_t  cls_item;
  logic              take;

  // Input side: accept and decode.
  mrlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cls_valid (cls_valid),
    .cls_item  (cls_item),
    .take      (take)
  );

  // Output side: line assembly and result queue.
  mrlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_item  (cls_item),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // Both queues come out of reset empty.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A reported message always has a length.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.event_res != mrlc_pkg::EV_NONE) |-> (result.event_length != 8'd0))
    else $error("message reported with zero length");

  // A frame holds at least its fixed header and trailer.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.event_res == mrlc_pkg::EV_FRAME) |-> (result.event_length >= 8'd19))
    else $error("frame shorter than its overhead");

  // The back end only takes an item that the front end holds.
  assert property (@(posedge clk) disable iff (rst) take |-> cls_valid)
    else $error("item taken from an empty input queue");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the modem reply line classifier (modem_reply_line_classifier).
// Holds its own model of the line assembly, a queue-fed driver and a result monitor.
// Depends on mrlc_pkg and the design files only.

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PAUSE_EVERY = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  mrlc_pkg::item_t   item = '0;
  logic              full;
  logic              empty;
  mrlc_pkg::result_t result;

  modem_reply_line_classifier u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Bytes waiting to be sent and replies waiting to come back.
  mrlc_pkg::item_t   rx_stream[$];
  mrlc_pkg::result_t line_reports[$];
  mrlc_pkg::result_t want;
  mrlc_pkg::result_t pred;

  int stream_total = 0;
  int accepted = 0;
  int loaded = 0;
  int errors = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  // Model state of the line assembler.
  mrlc_pkg::line_mode_t line_mode = mrlc_pkg::LM_NORMAL;
  int         fill = 0;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] len_hi = 8'h00;
  logic [7:0] head [mrlc_pkg::HEAD_DEPTH];
  logic       lost = 1'b0;

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Records one buffer write in the predicted reply and in the head copy.
  function automatic void store_byte(input int p, input logic [7:0] b);
    pred.write_valid = 1'b1;
    pred.write_index = 8'(p);
    pred.write_byte = b;
    if (p < mrlc_pkg::HEAD_DEPTH) begin
      head[p] = b;
    end
  endfunction

  // True when the first n bytes of the current line equal the prefix.
  function automatic logic head_match(input logic [mrlc_pkg::PFX_W-1:0] pfx, input int n);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (head[i] !== pfx[mrlc_pkg::PFX_W-1-8*i -: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    return (c > mrlc_pkg::CH_NINE) ? c - mrlc_pkg::HEX_ALPHA_BIAS
                                   : c - mrlc_pkg::HEX_DIGIT_BIAS;
  endfunction

  function automatic void back_to_normal();
    line_mode = mrlc_pkg::LM_NORMAL;
    fill = 0;
    frame_len = 8'h00;
  endfunction

  // Time and signal lines collect bytes until LF, keeping room for the zero.
  function automatic void text_byte(input logic [7:0] b, input logic [2:0] kind);
    if (b == mrlc_pkg::CH_LF) begin
      if (fill < mrlc_pkg::BUFFER_BYTES) begin
        store_byte(fill, 8'h00);
      end
      pred.event_res = kind;
      pred.event_length = 8'(fill + 1);
      back_to_normal();
    end else if (b != mrlc_pkg::CH_CR && fill < mrlc_pkg::BUFFER_BYTES - 1) begin
      store_byte(fill, b);
      fill++;
    end
  endfunction

  // Works out the reply to one item and advances the model state.
  task automatic classify_byte(input mrlc_pkg::item_t it, output mrlc_pkg::result_t r);
    logic [7:0] b;
    int pos;
    int stop_at;
    b = it.rx_byte;
    pred = '0;
    if (it.mode == mrlc_pkg::MODE_CLEAR) begin
      lost = 1'b0;
    end else begin
      case (line_mode)
        mrlc_pkg::LM_FRAME: begin
          pos = fill;
          if (pos < mrlc_pkg::BUFFER_BYTES - 1) begin
            store_byte(pos, b);
          end
          if (pos == mrlc_pkg::LEN_HI_POS) begin
            len_hi = b;
          end
          fill = pos + 1;
          if (fill == mrlc_pkg::LEN_DONE_FILL) begin
            frame_len = (hex_nibble(len_hi) << 4) + hex_nibble(b);
          end
          stop_at = int'(frame_len) + int'(mrlc_pkg::FRAME_OVERHEAD);
          if (fill == stop_at && b == mrlc_pkg::CH_ETX) begin
            // A frame whose end lies past the buffer is dropped silently.
            if (pos <= mrlc_pkg::BUFFER_BYTES - 2) begin
              pred.event_res = mrlc_pkg::EV_FRAME;
              pred.event_length = 8'(fill + 1);
            end
            back_to_normal();
          end else if (fill > stop_at) begin
            back_to_normal();
          end
        end
        mrlc_pkg::LM_TIME: text_byte(b, mrlc_pkg::EV_TIME);
        mrlc_pkg::LM_SIGNAL: text_byte(b, mrlc_pkg::EV_SIGNAL);
        default: begin
          if (b == mrlc_pkg::CH_LF || fill >= mrlc_pkg::BUFFER_BYTES - 2) begin
            // Line end: the zero is written and a non-empty line is reported.
            store_byte(fill, 8'h00);
            if (fill >= 1) begin
              pred.event_res = (fill >= 4 && head_match({mrlc_pkg::PFX_SMS, 64'h0}, 4))
                             ? mrlc_pkg::EV_SMS : mrlc_pkg::EV_AT;
              pred.event_length = 8'(fill + 1);
            end
            fill = 0;
          end else if (b != mrlc_pkg::CH_CR) begin
            store_byte(fill, b);
            fill++;
            if (b == mrlc_pkg::CH_STX) begin
              store_byte(0, b);
              fill = 1;
              frame_len = 8'h00;
              line_mode = mrlc_pkg::LM_FRAME;
            end else if (fill == mrlc_pkg::LEN_TIME &&
                         head_match(mrlc_pkg::PFX_TIME, mrlc_pkg::LEN_TIME)) begin
              fill = 0;
              line_mode = mrlc_pkg::LM_TIME;
            end else if (fill == mrlc_pkg::LEN_SIG &&
                         head_match(mrlc_pkg::PFX_SIG, mrlc_pkg::LEN_SIG)) begin
              fill = 0;
              line_mode = mrlc_pkg::LM_SIGNAL;
            end else if ((fill == mrlc_pkg::LEN_CLOSED &&
                          head_match(mrlc_pkg::PFX_CLOSED, mrlc_pkg::LEN_CLOSED)) ||
                         (fill == mrlc_pkg::LEN_FAIL &&
                          head_match(mrlc_pkg::PFX_FAIL, mrlc_pkg::LEN_FAIL))) begin
              fill = 0;
              lost = 1'b1;
            end
          end
        end
      endcase
    end
    pred.link_lost = lost;
    r = pred;
  endtask

  // Stimulus helpers.
  function automatic void add_byte(input logic [7:0] b);
    rx_stream.push_back({mrlc_pkg::MODE_RX, b});
  endfunction

  function automatic void add_clear();
    rx_stream.push_back({mrlc_pkg::MODE_CLEAR, 8'($urandom)});
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endfunction

  // Printable text with an occasional CR mixed in.
  function automatic void add_text(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        add_byte(mrlc_pkg::CH_CR);
      end else begin
        add_byte(8'($urandom_range(32, 126)));
      end
    end
  endfunction

  function automatic void end_line();
    if ($urandom_range(0, 1) == 1) begin
      add_byte(mrlc_pkg::CH_CR);
    end
    add_byte(mrlc_pkg::CH_LF);
  endfunction

  // Stimulus, end of run and final verdict.
  initial begin
    string hex_chars;
    string s;
    int n;
    int flen_pick;
    int shape;
    hex_chars = "0123456789ABCDEF";
    for (int i = 0; i < mrlc_pkg::HEAD_DEPTH; i++) begin
      head[i] = 8'h00;
    end

    // Directed part: dropped CR, empty line, byte extremes, SMS, link loss and its clear.
    add_byte(mrlc_pkg::CH_CR);
    add_byte(mrlc_pkg::CH_LF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(mrlc_pkg::CH_LF);
    add_str("0891");
    add_byte(mrlc_pkg::CH_LF);
    add_str("CLOSED");
    rx_stream.push_back({mrlc_pkg::MODE_CLEAR, 8'hFF});
    add_str("+CSQ: 9");
    add_byte(mrlc_pkg::CH_LF);

    // Random part: mostly well-formed lines and frames, some noise and broken ones.
    while (rx_stream.size() < RANDOM_ITEMS + 25) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          add_text($urandom_range(0, 20));
          end_line();
        end
        4, 5: begin
          add_str("0891");
          n = $urandom_range(0, 20);
          for (int i = 0; i < n; i++) begin
            add_byte(hex_chars[$urandom_range(0, 15)]);
          end
          end_line();
        end
        6, 7, 8: begin
          flen_pick = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 12);
          shape = $urandom_range(0, 9);
          add_byte(mrlc_pkg::CH_STX);
          repeat (12) add_byte(8'($urandom));
          if (shape == 9) begin
            // Length digits, maybe not hex: the frame length is whatever they decode to.
            repeat (22) add_byte(8'($urandom));
            end_line();
          end else begin
            add_byte(hex_chars[flen_pick / 16]);
            add_byte(hex_chars[flen_pick % 16]);
            repeat (flen_pick + 2) add_byte(8'($urandom));
            if (shape < 7) begin
              add_byte(mrlc_pkg::CH_ETX);
            end else begin
              // Wrong terminator, then one more byte to overrun the frame.
              add_byte(8'($urandom_range(4, 255)));
              add_byte(8'($urandom));
            end
          end
        end
        9, 10: begin
          add_str("*PSUTTZ:");
          add_text(($urandom_range(0, 29) == 0) ? $urandom_range(230, 250)
                                                : $urandom_range(0, 20));
          end_line();
        end
        11, 12: begin
          add_str("+CSQ: ");
          add_text($urandom_range(0, 6));
          end_line();
        end
        13: begin
          add_str(($urandom_range(0, 1) == 1) ? "CLOSED" : "CONNECT FAIL");
          if ($urandom_range(0, 1) == 1) begin
            end_line();
          end
        end
        14: add_clear();
        15, 16: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              add_clear();
            end else begin
              add_byte(8'($urandom));
            end
          end
        end
        17: begin
          // A prefix cut short, so the line stays an ordinary reply.
          case ($urandom_range(0, 4))
            0: s = "0891";
            1: s = "*PSUTTZ:";
            2: s = "+CSQ: ";
            3: s = "CLOSED";
            default: s = "CONNECT FAIL";
          endcase
          n = $urandom_range(1, s.len() - 1);
          for (int i = 0; i < n; i++) begin
            add_byte(s[i]);
          end
          add_text($urandom_range(0, 10));
          end_line();
        end
        18: begin
          // Now and then a line long enough to fill the buffer.
          add_text(($urandom_range(0, 3) == 0) ? $urandom_range(230, 245)
                                               : $urandom_range(0, 20));
          end_line();
        end
        default: end_line();
      endcase
    end
    stream_total = rx_stream.size();

    // Reset.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transfer in, then for every reply, then a short drain.
    while (accepted < stream_total) @(posedge clk);
    while (line_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_reports.size() != 0) begin
      $error("%0d expected replies never arrived", line_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Driver: predicts each accepted item and feeds the next one after a random gap.
  always @(posedge clk) begin
    mrlc_pkg::result_t r;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        classify_byte(item, r);
        line_reports.push_back(r);
        accepted++;
      end
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (loaded != 0 && loaded % PAUSE_EVERY == 0 && rx_stream.size() != 0 &&
                     line_reports.size() != 0) begin
          // Hold off until every outstanding reply has come back.
          push <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          item <= rx_stream.pop_front();
          push <= 1'b1;
          loaded++;
          if ($urandom_range(0, 39) == 0) begin
            tx_quiet = ~tx_quiet;
          end
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 14);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each reply with the oldest prediction, with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (line_reports.size() == 0) begin
          $error("reply transfer with no expected reply");
          errors++;
        end else begin
          want = line_reports.pop_front();
          if (result.write_valid !== want.write_valid) begin
            $error("write_valid: expected %0d, got %0d", want.write_valid, result.write_valid);
            errors++;
          end
          if (result.write_index !== want.write_index) begin
            $error("write_index: expected %0d, got %0d", want.write_index, result.write_index);
            errors++;
          end
          if (result.write_byte !== want.write_byte) begin
            $error("write_byte: expected %0h, got %0h", want.write_byte, result.write_byte);
            errors++;
          end
          if (result.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, result.event_res);
            errors++;
          end
          if (result.event_length !== want.event_length) begin
            $error("event_length: expected %0d, got %0d", want.event_length,
                   result.event_length);
            errors++;
          end
          if (result.link_lost !== want.link_lost) begin
            $error("link_lost: expected %0d, got %0d", want.link_lost, result.link_lost);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          rx_quiet = ~rx_quiet;
        end
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 14);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      pop <= (rx_hold == 0);
    end
  end

endmodule

[modem_reply_line_classifier.f]
design/mrlc_pkg.sv
design/mrlc_front.sv
design/mrlc_back.sv
design/modem_reply_line_classifier.sv
tb/testbench.sv
